>>> hw/rtl/rt_pkg.sv
// Shared types and constants for the rank transform block.
// Field widths, result status codes and the result struct used by the
// scan controller and the top level. No dependencies.
`default_nettype none

package rt_pkg;

	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int RANK_W   = 6;

	// Result status codes
	localparam logic [STATUS_W-1:0] STATUS_RANK   = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_DUP    = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_SORTED = 2'd2;

	// One result offered by the scan controller to the output register
	typedef struct packed {
		logic                valid;
		logic [STATUS_W-1:0] status;
		logic [RANK_W-1:0]   rank;
		logic                end_of_run;
	} res_t;

endpackage

`default_nettype wire

>>> hw/rtl/rank_transform_with_checks.sv
// Top level of the rank transform: list loading, value RAM, scan controller
// and output register. Uses rt_pkg, rt_ram and rt_ctrl.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-----------------------------
//  item     | item_valid / item_stall    | value, last
//  result   | result_valid / result_stall| status, rank, end_of_run
//
// Loading accepts one element per cycle. After the element flagged last, the
// controller sweeps the RAM through its one read port with one comparator:
// a check pass over all element pairs, then, unless the check ends the run,
// a rank pass that emits one result per element and waits on output stalls.
// item_stall is high for the whole sweep. A result waits in the output
// register under result_stall while the next list loads.
// Reset clears the element count, the controller and the output valid; the
// RAM is not cleared; data from entries beyond the current list is never used.
`default_nettype none

module rank_transform_with_checks #(
	parameter int MAX_COUNT = 64
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               item_valid,
	output logic                                    item_stall,
	input  wire logic signed [rt_pkg::VALUE_W-1:0]  value,
	input  wire logic                               last,
	output logic                                    result_valid,
	input  wire logic                               result_stall,
	output logic      [rt_pkg::STATUS_W-1:0]        status,
	output logic      [rt_pkg::RANK_W-1:0]          rank,
	output logic                                    end_of_run
);
	import rt_pkg::*;

	localparam int AW = $clog2(MAX_COUNT);
	localparam int CW = $clog2(MAX_COUNT + 1);

	logic [CW-1:0]             cnt_q;
	logic                      in_xfer;
	logic                      not_full;
	logic                      wr_en;
	logic                      start;
	logic [AW-1:0]             start_last_idx;
	logic                      busy;
	logic                      rd_en;
	logic [AW-1:0]             rd_addr;
	logic signed [VALUE_W-1:0] rd_data;
	res_t                      res;
	logic                      take;
	logic                      out_valid_q;
	logic [STATUS_W-1:0]       status_q;
	logic [RANK_W-1:0]         rank_q;
	logic                      end_q;

	// Load phase: store elements until the RAM is full, drop the rest
	assign item_stall     = busy;
	assign in_xfer        = item_valid && !item_stall;
	assign not_full       = (cnt_q < CW'(MAX_COUNT));
	assign wr_en          = in_xfer && not_full;
	assign start          = in_xfer && last;
	assign start_last_idx = not_full ? cnt_q[AW-1:0] : AW'(MAX_COUNT - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= '0;
		end else if (wr_en) begin
			cnt_q <= cnt_q + CW'(1);
		end
	end

	rt_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (MAX_COUNT)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (cnt_q[AW-1:0]),
		.wr_data (value),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	rt_ctrl #(
		.MAX_COUNT (MAX_COUNT)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.start_last_idx (start_last_idx),
		.busy           (busy),
		.rd_en          (rd_en),
		.rd_addr        (rd_addr),
		.rd_data        (rd_data),
		.res            (res),
		.take           (take)
	);

	// Output register: load when empty or when its transfer completes
	assign take = res.valid && (!out_valid_q || !result_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			status_q <= res.status;
			rank_q   <= res.rank;
			end_q    <= res.end_of_run;
		end
	end

	assign result_valid = out_valid_q;
	assign status       = status_q;
	assign rank         = rank_q;
	assign end_of_run   = end_q;

`ifndef SYNTHESIS
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && rd_en))
		else $error("RAM written and swept in the same cycle");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_COUNT))
		else $error("element count beyond RAM depth");
	a_sweep_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(in_xfer && last))
		else $error("sweep started without a final element");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/rt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Width and depth are parameters; no dependencies.
`default_nettype none

module rt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                       clk,
	input  wire logic                       wr_en,
	input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
	input  wire logic [WIDTH-1:0]           wr_data,
	input  wire logic                       rd_en,
	input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
	output logic      [WIDTH-1:0]           rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/rt_ctrl.sv
// Scan controller: sweeps the stored list with one comparator, first for
// duplicates and order, then for ranks. Uses rt_pkg; reads the value RAM.
`default_nettype none

module rt_ctrl #(
	parameter int MAX_COUNT = 64
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	input  wire logic [$clog2(MAX_COUNT)-1:0]        start_last_idx,
	output logic                                     busy,
	output logic                                     rd_en,
	output logic      [$clog2(MAX_COUNT)-1:0]        rd_addr,
	input  wire logic signed [rt_pkg::VALUE_W-1:0]   rd_data,
	output rt_pkg::res_t                             res,
	input  wire logic                                take
);
	import rt_pkg::*;

	localparam int AW = $clog2(MAX_COUNT);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_PREP = 3'd1;
	localparam logic [2:0] S_PLAT = 3'd2;
	localparam logic [2:0] S_SCAN = 3'd3;
	localparam logic [2:0] S_EMIT = 3'd4;

	logic [2:0]                state_q;
	logic [AW-1:0]             last_q;
	logic [AW-1:0]             p_q;
	logic [AW-1:0]             cq_q;
	logic signed [VALUE_W-1:0] pv_q;
	logic                      pass_q;
	logic                      dup_q;
	logic                      uns_q;
	logic [RANK_W-1:0]         rank_q;
	logic [STATUS_W-1:0]       res_status_q;
	logic [RANK_W-1:0]         res_rank_q;
	logic                      res_end_q;

	logic eq, gt, at_end, p_is_last, adj, dup_hit, uns_hit;

	// Compare the held element against the streamed one
	always_comb begin
		eq        = (pv_q == rd_data);
		gt        = (pv_q > rd_data);
		at_end    = (cq_q == last_q);
		p_is_last = (p_q == last_q);
		adj       = ({1'b0, cq_q} == ({1'b0, p_q} + {{AW{1'b0}}, 1'b1}));
		dup_hit   = eq && (cq_q != p_q);
		uns_hit   = adj && gt;
	end

	// Drive the RAM read port; reads only happen outside the load phase
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		case (state_q)
			S_PREP: begin
				rd_en   = 1'b1;
				rd_addr = p_q;
			end
			S_PLAT: begin
				rd_en   = 1'b1;
				rd_addr = '0;
			end
			S_SCAN: begin
				rd_en   = 1'b1;
				rd_addr = cq_q + AW'(1);
			end
			default: begin
				rd_en   = 1'b0;
				rd_addr = '0;
			end
		endcase
	end

	assign busy           = (state_q != S_IDLE);
	assign res.valid      = (state_q == S_EMIT);
	assign res.status     = res_status_q;
	assign res.rank       = res_rank_q;
	assign res.end_of_run = res_end_q;

	// Sequencer: outer index p, inner index cq, two passes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pass_q  <= 1'b0;
			dup_q   <= 1'b0;
			uns_q   <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						pass_q  <= 1'b0;
						dup_q   <= 1'b0;
						uns_q   <= 1'b0;
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					state_q <= S_PLAT;
				end
				S_PLAT: begin
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (!pass_q) begin
						dup_q <= dup_q | dup_hit;
						uns_q <= uns_q | uns_hit;
					end
					if (at_end) begin
						if (pass_q || !p_is_last) begin
							state_q <= pass_q ? S_EMIT : S_PREP;
						end else if (dup_q || dup_hit) begin
							state_q <= S_EMIT;
						end else if (!(uns_q || uns_hit)) begin
							state_q <= S_EMIT;
						end else begin
							pass_q  <= 1'b1;
							state_q <= S_PREP;
						end
					end
				end
				S_EMIT: begin
					if (take) begin
						state_q <= res_end_q ? S_IDLE : S_PREP;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers: indices, held element, rank count, result
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					last_q <= start_last_idx;
					p_q    <= '0;
				end
			end
			S_PLAT: begin
				pv_q   <= rd_data;
				cq_q   <= '0;
				rank_q <= '0;
			end
			S_SCAN: begin
				if (pass_q && gt) begin
					rank_q <= rank_q + RANK_W'(1);
				end
				if (at_end) begin
					if (pass_q) begin
						res_status_q <= STATUS_RANK;
						res_rank_q   <= rank_q + {{(RANK_W-1){1'b0}}, gt};
						res_end_q    <= p_is_last;
					end else if (!p_is_last) begin
						p_q <= p_q + AW'(1);
					end else if (dup_q || dup_hit) begin
						res_status_q <= STATUS_DUP;
						res_rank_q   <= '0;
						res_end_q    <= 1'b1;
					end else if (!(uns_q || uns_hit)) begin
						res_status_q <= STATUS_SORTED;
						res_rank_q   <= '0;
						res_end_q    <= 1'b1;
					end else begin
						p_q <= '0;
					end
				end else begin
					cq_q <= cq_q + AW'(1);
				end
			end
			S_EMIT: begin
				if (take && !res_end_q) begin
					p_q <= p_q + AW'(1);
				end
			end
			default: begin
				p_q <= p_q;
			end
		endcase
	end

`ifndef SYNTHESIS
	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (cq_q <= last_q && p_q <= last_q))
		else $error("scan index past end of list");
	a_check_result_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.status != STATUS_RANK) |-> (res.end_of_run && res.rank == '0))
		else $error("check result without end of run or with nonzero rank");
	a_emit_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !take) |=> (res.valid && $stable(res_rank_q) && $stable(res_end_q)))
		else $error("pending result changed before transfer");
`endif

endmodule

`default_nettype wire
